FILE: hdl/assert_macros.svh
// Assertion macros for the RTL files; included by the controller top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define ASSERT_NEXT(lbl, ck, rs, ante, cons)
`endif
`endif

FILE: hdl/cpid_pkg.sv
// Types, constants and helpers of the clamped PID controller.
`default_nettype none
package cpid_pkg;
  localparam int GAIN_W    = 16;
  localparam int TIME_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int MS_PER_S  = 1000;
  localparam int MS_W      = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HIGH   = 3'd4;

  localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd256;
  localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd0;
  localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd0;

  localparam logic REQ_COMPUTE = 1'b0;
  localparam logic REQ_RESET   = 1'b1;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_PREP = 10'b0000000010,
    S_MUL1 = 10'b0000000100,
    S_MUL2 = 10'b0000001000,
    S_DIV  = 10'b0000010000,
    S_ACC  = 10'b0000100000,
    S_CLMP = 10'b0001000000,
    S_SUM1 = 10'b0010000000,
    S_SUM2 = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  // result flags, saturated in bit 0
  typedef struct packed {
    logic zero_interval;
    logic saturated;
  } flags_t;

  function automatic logic [GAIN_W-1:0] gain_mag(input logic [GAIN_W-1:0] g);
    return g[GAIN_W-1] ? (~g + 1'b1) : g;
  endfunction
endpackage
`default_nettype wire

FILE: hdl/cpid_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`default_nettype none
module cpid_mul #(
  parameter int A_W = 16,
  parameter int B_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               busy,
  output logic [A_W+B_W-1:0] prod
);
  localparam int CNT_W = $clog2(B_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [A_W-1:0]   mcand;
  logic [A_W:0]     psum;

  assign busy = (cnt != '0);
  assign psum = {1'b0, prod[A_W+B_W-1:B_W]} + (prod[0] ? {1'b0, mcand} : {(A_W+1){1'b0}});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(B_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      prod  <= {{A_W{1'b0}}, b};
    end else if (busy) begin
      prod <= {psum, prod[B_W-1:1]};
    end
  end
endmodule
`default_nettype wire

FILE: hdl/cpid_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module cpid_div #(
  parameter int N_W = 32,
  parameter int D_W = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic           busy,
  output logic [N_W-1:0] quot
);
  localparam int CNT_W = $clog2(N_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   dvsr;
  logic [D_W-1:0]   rem;
  logic [D_W:0]     trial;

  assign busy  = (cnt != '0);
  assign trial = {rem, quot[N_W-1]} - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(N_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= divisor;
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      if (!trial[D_W]) begin
        rem <= trial[D_W-1:0];
      end else begin
        rem <= {rem[D_W-2:0], quot[N_W-1]};
      end
      quot <= {quot[N_W-2:0], ~trial[D_W]};
    end
  end
endmodule
`default_nettype wire

FILE: hdl/clamped_pid_controller_top.sv
// Clamped PID controller top: config registers, sequencer and fixed-point datapath.
// A compute beat steps through PREP, the bit-serial multiplies, the divisions, ACC, CLMP,
// SUM1, SUM2 and OUT to a result; the bit-serial integral division by 1000 is the longest step.
// A new beat is taken only once the previous one has reached the output register; a finished
// result waits there while the next beat is taken. A reset beat gives no result.
// rst (synchronous) restores the gains and limits and clears integral and history.
`default_nettype none
`include "assert_macros.svh"
module clamped_pid_controller_top
  import cpid_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [((DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W)-1:0] cfg_data,
  input  logic s_tvalid,
  output logic s_tready,
  // measurement, setpoint, elapsed_ms
  input  logic [((2*DATA_WIDTH+TIME_W+7)/8)*8-1:0] s_tdata,
  // req_type
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // drive
  output logic [((DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  // saturated, zero_interval
  output flags_t m_tuser
);
  localparam int DW    = DATA_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int SH    = FB - 8;
  localparam int PW    = DW + GAIN_W;
  localparam int NUMW  = PW + TIME_W;
  localparam int IDIVW = NUMW + SH;
  localparam int DNW   = PW + MS_W;
  localparam int IW    = DW + FB;
  localparam int AW    = IDIVW + 2;
  localparam int SW    = DW + FB + 21;
  localparam int OUT_W = ((DW + 7) / 8) * 8;

  state_t state, state_next;

  logic signed [GAIN_W-1:0] prop_gain, integ_gain, deriv_gain;
  logic signed [DW-1:0]     out_low, out_high;

  logic signed [DW-1:0]     meas, setp, last_meas;
  logic [TIME_W-1:0]        dt;
  logic                     zi;
  logic                     err_neg, diff_neg;
  logic signed [IW-1:0]     integ;
  logic signed [PW:0]       p_val;
  logic signed [IDIVW:0]    inc_s;
  logic signed [DNW:0]      d_s;
  logic signed [AW-1:0]     acc;
  logic signed [SW-1:0]     sum;

  logic                     in_acc;
  logic signed [DW:0]       err_w, diff_w;
  logic [DW:0]              err_abs, diff_abs;
  logic                     busy_p, busy_i, busy_d, busy_n, busy_k, busy_di, busy_dd;
  logic                     mul1_done, mul2_done, div_done;
  logic [PW-1:0]            prod_p, prod_i, prod_d;
  logic [NUMW-1:0]          prod_n;
  logic [DNW-1:0]           prod_k;
  logic [IDIVW-1:0]         quot_i;
  logic [DNW-1:0]           quot_d;
  logic [PW:0]              p_ext;
  logic [IDIVW:0]           i_ext;
  logic [DNW:0]             d_ext;
  logic signed [IW-1:0]     hi_f, lo_f;
  logic signed [AW-1:0]     hi_a, lo_a;
  logic signed [SW-1:0]     hi_s, lo_s, p_x, d_x, i_x;
  logic [DW-1:0]            drive_v;
  logic                     sat_v, out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign zi        = (dt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= PROP_GAIN_RST;
      integ_gain <= INTEG_GAIN_RST;
      deriv_gain <= DERIV_GAIN_RST;
      out_low    <= {1'b1, {(DW-1){1'b0}}};
      out_high   <= {1'b0, {(DW-1){1'b1}}};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROP_GAIN:  prop_gain  <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN: integ_gain <= cfg_data[GAIN_W-1:0];
        CFG_DERIV_GAIN: deriv_gain <= cfg_data[GAIN_W-1:0];
        CFG_OUT_LOW:    out_low    <= cfg_data[DW-1:0];
        CFG_OUT_HIGH:   out_high   <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  assign err_w    = {setp[DW-1], setp} - {meas[DW-1], meas};
  assign diff_w   = {meas[DW-1], meas} - {last_meas[DW-1], last_meas};
  assign err_abs  = err_w[DW] ? (~err_w + 1'b1) : err_w;
  assign diff_abs = diff_w[DW] ? (~diff_w + 1'b1) : diff_w;

  assign mul1_done = (state == S_MUL1) && !busy_p && !busy_i && !busy_d;
  assign mul2_done = (state == S_MUL2) && !busy_n && !busy_k;
  assign div_done  = (state == S_DIV) && !busy_di && !busy_dd;

  cpid_mul #(.A_W(DW), .B_W(GAIN_W)) u_mul_p (
    .clk(clk), .rst(rst), .start(state == S_PREP), .a(err_abs[DW-1:0]),
    .b(gain_mag(prop_gain)), .busy(busy_p), .prod(prod_p)
  );
  cpid_mul #(.A_W(DW), .B_W(GAIN_W)) u_mul_i (
    .clk(clk), .rst(rst), .start(state == S_PREP), .a(err_abs[DW-1:0]),
    .b(gain_mag(integ_gain)), .busy(busy_i), .prod(prod_i)
  );
  cpid_mul #(.A_W(DW), .B_W(GAIN_W)) u_mul_d (
    .clk(clk), .rst(rst), .start(state == S_PREP), .a(diff_abs[DW-1:0]),
    .b(gain_mag(deriv_gain)), .busy(busy_d), .prod(prod_d)
  );
  cpid_mul #(.A_W(PW), .B_W(TIME_W)) u_mul_n (
    .clk(clk), .rst(rst), .start(mul1_done), .a(prod_i), .b(dt),
    .busy(busy_n), .prod(prod_n)
  );
  cpid_mul #(.A_W(PW), .B_W(MS_W)) u_mul_k (
    .clk(clk), .rst(rst), .start(mul1_done), .a(prod_d), .b(MS_W'(MS_PER_S)),
    .busy(busy_k), .prod(prod_k)
  );
  cpid_div #(.N_W(IDIVW), .D_W(MS_W)) u_div_i (
    .clk(clk), .rst(rst), .start(mul2_done), .dividend(IDIVW'(prod_n) << SH),
    .divisor(MS_W'(MS_PER_S)), .busy(busy_di), .quot(quot_i)
  );
  cpid_div #(.N_W(DNW), .D_W(TIME_W)) u_div_d (
    .clk(clk), .rst(rst), .start(mul2_done), .dividend(prod_k), .divisor(dt),
    .busy(busy_dd), .quot(quot_d)
  );

  assign p_ext = {1'b0, prod_p};
  assign i_ext = {1'b0, quot_i};
  assign d_ext = {1'b0, quot_d};

  assign hi_f = {out_high, {FB{1'b0}}};
  assign lo_f = {out_low, {FB{1'b0}}};
  assign hi_a = {{(AW-IW){hi_f[IW-1]}}, hi_f};
  assign lo_a = {{(AW-IW){lo_f[IW-1]}}, lo_f};
  assign hi_s = {{(SW-IW){hi_f[IW-1]}}, hi_f};
  assign lo_s = {{(SW-IW){lo_f[IW-1]}}, lo_f};
  assign p_x  = {{(SW-PW-1){p_val[PW]}}, p_val};
  assign d_x  = {{(SW-DNW-1){d_s[DNW]}}, d_s};
  assign i_x  = {{(SW-IW){integ[IW-1]}}, integ};

  always_comb begin
    sat_v   = 1'b1;
    drive_v = out_high;
    if (sum > hi_s) begin
      drive_v = out_high;
    end else if (sum < lo_s) begin
      drive_v = out_low;
    end else begin
      sat_v   = 1'b0;
      drive_v = sum[FB+DW-1:FB];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && s_tuser == REQ_COMPUTE) state_next = S_PREP;
      end
      S_PREP: state_next = S_MUL1;
      S_MUL1: begin
        if (mul1_done) state_next = S_MUL2;
      end
      S_MUL2: begin
        if (mul2_done) state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = S_ACC;
      end
      S_ACC:  state_next = S_CLMP;
      S_CLMP: state_next = S_SUM1;
      S_SUM1: state_next = S_SUM2;
      S_SUM2: state_next = S_OUT;
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ     <= '0;
      last_meas <= '0;
    end else if (in_acc && s_tuser == REQ_RESET) begin
      integ     <= '0;
      last_meas <= '0;
    end else if (state == S_PREP) begin
      last_meas <= meas;
    end else if (state == S_CLMP) begin
      if (acc > hi_a) begin
        integ <= hi_f;
      end else if (acc < lo_a) begin
        integ <= lo_f;
      end else begin
        integ <= acc[IW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      meas <= s_tdata[DW-1:0];
      setp <= s_tdata[2*DW-1:DW];
      dt   <= s_tdata[2*DW+TIME_W-1:2*DW];
    end
    if (state == S_PREP) begin
      err_neg  <= err_w[DW];
      diff_neg <= diff_w[DW];
    end
    if (mul1_done) begin
      p_val <= (prop_gain[GAIN_W-1] ^ err_neg) ? (~p_ext + 1'b1) : p_ext;
    end
    if (div_done) begin
      inc_s <= (integ_gain[GAIN_W-1] ^ err_neg) ? (~i_ext + 1'b1) : i_ext;
      if (zi) begin
        d_s <= '0;
      end else begin
        d_s <= (deriv_gain[GAIN_W-1] ^ diff_neg) ? (~d_ext + 1'b1) : d_ext;
      end
    end
    if (state == S_ACC) begin
      acc <= {{(AW-IW){integ[IW-1]}}, integ} + {inc_s[IDIVW], inc_s};
    end
    if (state == S_SUM1) begin
      sum <= (p_x <<< SH) + i_x;
    end else if (state == S_SUM2) begin
      sum <= sum - (d_x <<< SH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata                 <= OUT_W'(drive_v);
      m_tuser.saturated       <= sat_v;
      m_tuser.zero_interval   <= zi;
    end
  end

  `ASSERT_IMPLY(a_head_idle, clk, rst, state == S_IDLE, !busy_p && !busy_i && !busy_d)
  `ASSERT_IMPLY(a_tail_idle, clk, rst, state == S_IDLE, !busy_n && !busy_k && !busy_di && !busy_dd)
  `ASSERT_NEXT(a_reset_clears, clk, rst, in_acc && s_tuser == REQ_RESET, integ == '0 && last_meas == '0)
  `ASSERT_IMPLY(a_integ_lim, clk, rst, state == S_SUM1 && out_low <= out_high, integ >= lo_f && integ <= hi_f)
endmodule
`default_nettype wire

FILE: tb/pid_checker.sv
// Scoreboard for the clamped PID controller: tracks config, predicts each result, compares.
`default_nettype none
module pid_checker
  import cpid_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,
  input  flags_t      m_tuser,
  output int          outstanding,
  output int          errors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC = 16;
  localparam longint ONE  = longint'(1) << FRAC;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               saturated;
    logic               zero_interval;
  } pid_result_t;

  longint kp, ki, kd, lim_lo, lim_hi;
  longint integ, prev_meas;
  pid_result_t expected_results[$];

  function automatic longint mag64(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic pid_result_t predict_result(input logic signed [15:0] meas,
                                                  input logic signed [15:0] setp,
                                                  input logic [15:0] dt);
    longint err, p, d, diff, inc, sum, hi, lo, dt_l;
    pid_result_t r;
    err  = longint'(setp) - longint'(meas);
    dt_l = longint'(dt);
    p    = kp * err;
    hi   = lim_hi * ONE;
    lo   = lim_lo * ONE;

    // increment carries FRAC fraction bits: gain Q8.8 times ms, over 1000
    inc = ((mag64(ki) * mag64(err) * dt_l) << (FRAC - 8)) / MS_PER_S;
    if ((ki < 0) != (err < 0)) inc = -inc;
    integ = integ + inc;
    if (integ > hi) integ = hi;
    else if (integ < lo) integ = lo;

    if (dt == 16'd0) begin
      d = 0;
    end else begin
      diff = longint'(meas) - prev_meas;
      d = (mag64(kd) * mag64(diff) * MS_PER_S) / dt_l;
      if ((kd < 0) != (diff < 0)) d = -d;
    end
    prev_meas = longint'(meas);

    sum = (p - d) * (longint'(1) << (FRAC - 8)) + integ;
    r.zero_interval = (dt == 16'd0);
    if (sum > hi) begin
      r.drive = lim_hi[15:0];
      r.saturated = 1'b1;
    end else if (sum < lo) begin
      r.drive = lim_lo[15:0];
      r.saturated = 1'b1;
    end else begin
      r.drive = 16'(sum >>> FRAC);
      r.saturated = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    pid_result_t want;
    if (rst) begin
      kp = 256;
      ki = 0;
      kd = 0;
      lim_lo = -32768;
      lim_hi = 32767;
      integ = 0;
      prev_meas = 0;
      expected_results.delete();
      outstanding = 0;
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROP_GAIN:  kp = longint'($signed(cfg_data));
          CFG_INTEG_GAIN: ki = longint'($signed(cfg_data));
          CFG_DERIV_GAIN: kd = longint'($signed(cfg_data));
          CFG_OUT_LOW:    lim_lo = longint'($signed(cfg_data));
          CFG_OUT_HIGH:   lim_hi = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no result pending");
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.drive)
            report_mismatch($sformatf("drive got %0d want %0d",
                                      $signed(m_tdata), want.drive));
          if (m_tuser.saturated !== want.saturated)
            report_mismatch($sformatf("saturated got %b want %b",
                                      m_tuser.saturated, want.saturated));
          if (m_tuser.zero_interval !== want.zero_interval)
            report_mismatch($sformatf("zero_interval got %b want %b",
                                      m_tuser.zero_interval, want.zero_interval));
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == REQ_RESET) begin
          integ = 0;
          prev_meas = 0;
        end else begin
          expected_results.push_back(predict_result($signed(s_tdata[15:0]),
                                                    $signed(s_tdata[31:16]),
                                                    s_tdata[47:32]));
        end
      end
      outstanding = expected_results.size();
    end
  end
endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench top for the clamped PID controller: stimulus, config phases, watchdog and verdict.
`default_nettype none
module tb;
  import cpid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 150;
  localparam int SEGMENTS       = 10;
  localparam int SEG_ITEMS      = 150;

  // register indexes past the defined ones
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [47:0]          s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;
  flags_t               m_tuser;

  int outstanding;
  int errors;
  int src_idle = 0;
  int dst_idle = 0;
  int quiet_cycles = 0;

  logic signed [15:0] meas_cur = '0;
  logic signed [15:0] setp_cur = '0;

  clamped_pid_controller_top DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  pid_checker scoreboard (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .outstanding(outstanding), .errors(errors)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= dst_idle);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_item(input logic req, input logic [15:0] meas,
                           input logic [15:0] setp, input logic [15:0] dt);
    @(negedge clk);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = req;
    s_tdata  = {dt, setp, meas};
    do @(posedge clk); while (!s_tready);
  endtask

  // hold off the sender until every pending result beat has drained
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_all(input logic [15:0] kp, input logic [15:0] ki, input logic [15:0] kd,
                           input logic [15:0] lo, input logic [15:0] hi);
    write_reg(CFG_PROP_GAIN, kp);
    write_reg(CFG_INTEG_GAIN, ki);
    write_reg(CFG_DERIV_GAIN, kd);
    write_reg(CFG_OUT_LOW, lo);
    write_reg(CFG_OUT_HIGH, hi);
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(2048)) - 16'd1024;
      2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom_range(512));
    endcase
  endfunction

  task automatic random_item();
    int k;
    logic [15:0] dt;
    k = $urandom_range(99);
    if (k < 6) begin
      send_item(REQ_RESET, 16'($urandom), 16'($urandom), 16'($urandom));
      meas_cur = '0;
    end else if (k < 14) begin
      send_item(REQ_COMPUTE, 16'($urandom), 16'($urandom), 16'($urandom));
    end else begin
      if ($urandom_range(19) == 0)
        setp_cur = 16'($urandom_range(4000)) - 16'sd2000;
      meas_cur = meas_cur + (setp_cur - meas_cur) / 16'sd8
                 + $signed(16'($urandom_range(400))) - 16'sd200;
      dt = 16'($urandom_range(100, 1));
      if ($urandom_range(19) == 0) dt = 16'd0;
      else if ($urandom_range(29) == 0) dt = 16'hffff;
      send_item(REQ_COMPUTE, meas_cur, setp_cur, dt);
    end
  endtask

  initial begin
    logic signed [15:0] lo_v, hi_v, tmp;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset defaults: proportional only
    send_item(REQ_COMPUTE, 16'sd0, 16'sd0, 16'd0);
    send_item(REQ_COMPUTE, 16'sd32767, -16'sd32768, 16'hffff);
    send_item(REQ_COMPUTE, -16'sd32768, 16'sd32767, 16'd0);
    drain();

    write_all(16'd256, 16'd512, 16'd128, 16'h8000, 16'h7fff);
    send_item(REQ_COMPUTE, 16'sd100, 16'sd200, 16'd1000);
    send_item(REQ_COMPUTE, 16'sd100, 16'sd200, 16'd1);
    send_item(REQ_COMPUTE, -16'sd32768, 16'sd32767, 16'hffff);
    send_item(REQ_COMPUTE, 16'sd32767, 16'sd32767, 16'd1);
    send_item(REQ_RESET, 16'hffff, 16'hffff, 16'hffff);
    send_item(REQ_COMPUTE, 16'sd5, 16'sd2, 16'd3);
    send_item(REQ_RESET, 16'h0000, 16'h0000, 16'h0000);
    send_item(REQ_RESET, 16'h1234, 16'h5678, 16'h9abc);
    send_item(REQ_COMPUTE, -16'sd7, 16'sd0, 16'd0);
    send_item(REQ_COMPUTE, 16'sd0, 16'sd0, 16'd1);
    drain();

    write_all(16'h8000, 16'h8000, 16'h8000, -16'sd1000, 16'sd1000);
    send_item(REQ_COMPUTE, 16'sd1, 16'sd0, 16'd1);
    send_item(REQ_COMPUTE, -16'sd1, 16'sd0, 16'd3);
    send_item(REQ_COMPUTE, 16'sd32767, -16'sd32768, 16'hffff);
    drain();

    // crossed limits
    write_all(16'h7fff, 16'h7fff, 16'h7fff, 16'sd100, -16'sd100);
    send_item(REQ_COMPUTE, 16'sd0, 16'sd0, 16'd0);
    send_item(REQ_COMPUTE, 16'sd10, 16'sd20, 16'd5);
    send_item(REQ_COMPUTE, -16'sd10, -16'sd20, 16'd5);
    drain();

    write_reg(CFG_SPARE_FIRST, 16'($urandom));
    write_reg(CFG_SPARE_LAST, 16'($urandom));

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 4) begin
        src_idle = 14;
        dst_idle = 69;
      end else if (seg < 7) begin
        src_idle = 69;
        dst_idle = 14;
      end else begin
        src_idle = 0;
        dst_idle = 0;
      end
      drain();
      case ($urandom_range(3))
        0: begin
          lo_v = -16'sd32768;
          hi_v = 16'sd32767;
        end
        1: begin
          lo_v = 16'($urandom);
          hi_v = 16'($urandom);
          if (lo_v > hi_v) begin
            tmp = lo_v;
            lo_v = hi_v;
            hi_v = tmp;
          end
        end
        2: begin
          hi_v = -16'($urandom_range(3000, 1));
          lo_v = -hi_v;
        end
        default: begin
          lo_v = -16'($urandom_range(500));
          hi_v = 16'($urandom_range(500));
        end
      endcase
      write_all(pick_gain(), pick_gain(), pick_gain(), lo_v, hi_v);
      setp_cur = 16'($urandom_range(4000)) - 16'sd2000;
      for (int i = 0; i < SEG_ITEMS; i++) random_item();
    end

    drain();
    @(negedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
